@@ design/scfp_pkg.sv @@
// Shared types and constants of the servo command frame parser.
package scfp_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 5;
  localparam int CNT_W  = 4;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_ENTRY  = 2'd1,
    EV_REJECT = 2'd2,
    EV_STOP   = 2'd3
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_START  = 3'd0,
    CFG_FRAME_END    = 3'd1,
    CFG_STOP         = 3'd2,
    CFG_ENGINE_FIRST = 3'd3,
    CFG_ENGINE_LAST  = 3'd4,
    CFG_DEGREE_LOW   = 3'd5,
    CFG_DEGREE_HIGH  = 3'd6
  } cfg_idx_t;

  localparam logic [BYTE_W-1:0] RST_FRAME_START  = 8'd91;
  localparam logic [BYTE_W-1:0] RST_FRAME_END    = 8'd93;
  localparam logic [BYTE_W-1:0] RST_STOP         = 8'd35;
  localparam logic [BYTE_W-1:0] RST_ENGINE_FIRST = 8'd65;
  localparam logic [BYTE_W-1:0] RST_ENGINE_LAST  = 8'd82;
  localparam logic [BYTE_W-1:0] RST_DEGREE_LOW   = 8'd128;
  localparam logic [BYTE_W-1:0] RST_DEGREE_HIGH  = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_DECODE  = 2'd1,
    ST_SCAN_RD = 2'd2,
    ST_SCAN_WR = 2'd3
  } state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic scan_rd;
    logic scan_emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_req;
    logic scan_hold;
    logic scan_done;
  } sts_t;

endpackage

@@ design/scfp_ctrl.sv @@
// Controller state machine of the servo command frame parser.
module scfp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  scfp_pkg::sts_t sts,
  output scfp_pkg::cmd_t cmd
);
  import scfp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts.out_free) begin
          state_nxt = sts.scan_req ? ST_SCAN_RD : ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_WR;
      end
      ST_SCAN_WR: begin
        if (!sts.scan_hold) begin
          state_nxt = sts.scan_done ? ST_IDLE : ST_SCAN_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd.load      = 1'b0;
    cmd.decode    = 1'b0;
    cmd.scan_rd   = 1'b0;
    cmd.scan_emit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DECODE: begin
        cmd.decode = sts.out_free;
      end
      ST_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
      end
      ST_SCAN_WR: begin
        cmd.scan_emit = !sts.scan_hold;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

@@ design/scfp_dp.sv @@
// Datapath of the servo command frame parser: registers, pending table and result register.
module scfp_dp #(
  parameter int MAX_FRAME_BYTES = 15,
  parameter int NUM_SERVOS      = 18
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [scfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scfp_pkg::BYTE_W-1:0]       cfg_wdata,
  input  logic [scfp_pkg::BYTE_W-1:0]       in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_event_res,
  output logic [scfp_pkg::IDX_W-1:0]        out_servo_index,
  output logic [scfp_pkg::BYTE_W-1:0]       out_servo_position,
  output logic                              out_last,
  input  scfp_pkg::cmd_t                    cmd,
  output scfp_pkg::sts_t                    sts
);
  import scfp_pkg::*;

  localparam int AW = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam logic [BYTE_W:0] NUM_SERVOS_C = (BYTE_W + 1)'(NUM_SERVOS);
  localparam logic [CNT_W-1:0] MAX_BYTES_C = CNT_W'(MAX_FRAME_BYTES);

  logic [BYTE_W-1:0] start_r, end_r, stop_r, eng_first_r, eng_last_r, deg_low_r, deg_high_r;

  logic [BYTE_W-1:0]     byte_r;
  logic                  in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  eng_pend_r, eng_pend_nxt;
  logic [AW-1:0]         eng_sel_r, eng_sel_nxt;
  logic                  pair_seen_r, pair_seen_nxt;
  logic [NUM_SERVOS-1:0] pend_valid_r, pend_valid_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [BYTE_W-1:0]     rd_data_r;
  logic [BYTE_W-1:0]     pending_code [NUM_SERVOS];

  logic              out_valid_r, out_valid_nxt;
  event_t            out_event_r, out_event_nxt;
  logic [IDX_W-1:0]  out_index_r, out_index_nxt;
  logic [BYTE_W-1:0] out_pos_r, out_pos_nxt;
  logic              out_last_r, out_last_nxt;

  logic              is_start, is_end, is_stop;
  logic              mem_we;
  logic [CNT_W-1:0]  count_inc;
  logic [BYTE_W-1:0] eng_diff;
  logic              eng_hit, deg_hit;
  logic [NUM_SERVOS:0] valid_shift;
  logic              more_above;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= RST_FRAME_START;
      end_r       <= RST_FRAME_END;
      stop_r      <= RST_STOP;
      eng_first_r <= RST_ENGINE_FIRST;
      eng_last_r  <= RST_ENGINE_LAST;
      deg_low_r   <= RST_DEGREE_LOW;
      deg_high_r  <= RST_DEGREE_HIGH;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAME_START:  start_r     <= cfg_wdata;
        CFG_FRAME_END:    end_r       <= cfg_wdata;
        CFG_STOP:         stop_r      <= cfg_wdata;
        CFG_ENGINE_FIRST: eng_first_r <= cfg_wdata;
        CFG_ENGINE_LAST:  eng_last_r  <= cfg_wdata;
        CFG_DEGREE_LOW:   deg_low_r   <= cfg_wdata;
        CFG_DEGREE_HIGH:  deg_high_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign is_start  = (byte_r == start_r);
  assign is_end    = !is_start && (byte_r == end_r);
  assign is_stop   = !is_start && !is_end && (byte_r == stop_r);
  assign count_inc = count_r + CNT_W'(1);
  assign eng_diff  = byte_r - eng_first_r;
  assign eng_hit   = (byte_r >= eng_first_r) && (byte_r <= eng_last_r);
  assign deg_hit   = (byte_r >= deg_low_r) && (byte_r <= deg_high_r);

  assign valid_shift = {1'b0, pend_valid_r} >> idx_r;
  assign more_above  = |valid_shift[NUM_SERVOS:1];

  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.scan_req  = is_end && in_frame_r && pair_seen_r;
  assign sts.scan_hold = pend_valid_r[idx_r] && !sts.out_free;
  assign sts.scan_done = !more_above;

  always_comb begin
    in_frame_nxt   = in_frame_r;
    count_nxt      = count_r;
    eng_pend_nxt   = eng_pend_r;
    eng_sel_nxt    = eng_sel_r;
    pair_seen_nxt  = pair_seen_r;
    pend_valid_nxt = pend_valid_r;
    idx_nxt        = idx_r;
    mem_we         = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    out_event_nxt  = out_event_r;
    out_index_nxt  = out_index_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;

    if (cmd.decode) begin
      idx_nxt       = '0;
      out_valid_nxt = !sts.scan_req;
      out_event_nxt = EV_NONE;
      out_index_nxt = '0;
      out_pos_nxt   = '0;
      out_last_nxt  = 1'b1;
      if (is_start) begin
        pend_valid_nxt = '0;
        in_frame_nxt   = 1'b1;
        count_nxt      = '0;
        eng_pend_nxt   = 1'b0;
        pair_seen_nxt  = 1'b0;
      end else if (is_end) begin
        in_frame_nxt  = 1'b0;
        count_nxt     = '0;
        eng_pend_nxt  = 1'b0;
        pair_seen_nxt = 1'b0;
        if (!sts.scan_req) out_event_nxt = EV_REJECT;
      end else if (is_stop) begin
        pend_valid_nxt = '0;
        pair_seen_nxt  = 1'b0;
        out_event_nxt  = EV_STOP;
      end else if (!in_frame_r) begin
        out_event_nxt = EV_REJECT;
      end else if (byte_r != '0) begin
        count_nxt = count_inc;
        if (count_inc >= MAX_BYTES_C) begin
          in_frame_nxt  = 1'b0;
          count_nxt     = '0;
          eng_pend_nxt  = 1'b0;
          pair_seen_nxt = 1'b0;
          out_event_nxt = EV_REJECT;
        end else if (eng_hit) begin
          if ({1'b0, eng_diff} < NUM_SERVOS_C) begin
            eng_pend_nxt = 1'b1;
            eng_sel_nxt  = AW'(eng_diff);
          end
        end else if (eng_pend_r && deg_hit) begin
          eng_pend_nxt              = 1'b0;
          mem_we                    = 1'b1;
          pend_valid_nxt[eng_sel_r] = 1'b1;
          pair_seen_nxt             = 1'b1;
        end
      end
    end

    if (cmd.scan_emit) begin
      if (pend_valid_r[idx_r]) begin
        out_valid_nxt = 1'b1;
        out_event_nxt = EV_ENTRY;
        out_index_nxt = IDX_W'(idx_r);
        out_pos_nxt   = rd_data_r - deg_low_r;
        out_last_nxt  = !more_above;
      end
      if (more_above) idx_nxt = idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      count_r      <= '0;
      eng_pend_r   <= 1'b0;
      eng_sel_r    <= '0;
      pair_seen_r  <= 1'b0;
      pend_valid_r <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      in_frame_r   <= in_frame_nxt;
      count_r      <= count_nxt;
      eng_pend_r   <= eng_pend_nxt;
      eng_sel_r    <= eng_sel_nxt;
      pair_seen_r  <= pair_seen_nxt;
      pend_valid_r <= pend_valid_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) byte_r <= in_rx_byte;
    out_event_r <= out_event_nxt;
    out_index_r <= out_index_nxt;
    out_pos_r   <= out_pos_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) pending_code[eng_sel_r] <= byte_r;
    if (cmd.scan_rd) rd_data_r <= pending_code[idx_r];
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = out_event_r;
  assign out_servo_index    = out_index_r;
  assign out_servo_position = out_pos_r;
  assign out_last           = out_last_r;

  // A pair can only have been seen while some servo is still pending.
  a_pair_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pair_seen_r |-> (pend_valid_r != '0))
    else $error("pair seen with an empty pending table");

  // Outside a frame the byte count and the engine selection flag are clear.
  a_idle_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (count_r == '0) && !eng_pend_r)
    else $error("frame state left over after close");

  // A decoded byte that does not start a scan always presents a result.
  a_decode_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decode && !sts.scan_req |=> out_valid_r && out_last_r)
    else $error("decoded byte produced no result");

  // Emitting a pending entry presents an entry result.
  a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_emit && pend_valid_r[idx_r] |=> out_valid_r && (out_event_r == EV_ENTRY))
    else $error("pending entry not presented");

endmodule

@@ design/servo_command_frame_parser_core.sv @@
// Top level of the servo command frame parser.
// Each received byte is captured in the idle state and decoded in the decode state once
// the result register is free. A frame end code that closes a frame with at least one
// command then walks the pending table through its single read port, with a read state
// and an emit state per entry, up to the highest pending servo. Results leave through a
// one-entry register, so a new byte is taken while the previous result waits.
module servo_command_frame_parser_core #(
  parameter int MAX_FRAME_BYTES = 15,
  parameter int NUM_SERVOS      = 18
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [scfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scfp_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [scfp_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_event_res,
  output logic [scfp_pkg::IDX_W-1:0]     out_servo_index,
  output logic [scfp_pkg::BYTE_W-1:0]    out_servo_position,
  output logic                           out_last
);
  import scfp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  scfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  scfp_dp #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .NUM_SERVOS      (NUM_SERVOS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_res      (out_event_res),
    .out_servo_index    (out_servo_index),
    .out_servo_position (out_servo_position),
    .out_last           (out_last),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

@@ bench/tb_servo_command_frame_parser_core.sv @@
// Self-checking testbench of the servo command frame parser core: directed and random byte streams.
`timescale 1ns / 1ps

module tb_servo_command_frame_parser_core;
  import scfp_pkg::*;

  localparam int MAX_BYTES      = 15;
  localparam int SERVO_COUNT    = 18;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    event_t           ev;
    logic [IDX_W-1:0] idx;
    logic [7:0]       pos;
    logic             last;
  } servo_report_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_event_res;
  logic [IDX_W-1:0]     out_servo_index;
  logic [7:0]           out_servo_position;
  logic                 out_last;

  servo_report_t reports_due[$];
  logic [7:0]    code_reg [0:6];
  logic          frame_open;
  int            frame_bytes;
  logic          engine_armed;
  logic [4:0]    engine_sel;
  logic          pair_seen;
  logic          cmd_valid [0:SERVO_COUNT-1];
  logic [7:0]    cmd_code [0:SERVO_COUNT-1];

  bit send_idle_en;
  bit recv_idle_en;
  int fault_count;
  int bytes_sent;
  int results_checked;
  int frames_accepted;
  int idle_cycles;

  wire in_xfer  = in_valid && !in_stall;
  wire out_xfer = out_valid && !out_stall;

  servo_command_frame_parser_core #(
    .MAX_FRAME_BYTES(MAX_BYTES),
    .NUM_SERVOS     (SERVO_COUNT)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_res     (out_event_res),
    .out_servo_index   (out_servo_index),
    .out_servo_position(out_servo_position),
    .out_last          (out_last)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void add_report(event_t ev, int idx, logic [7:0] pos, logic lst);
    servo_report_t r;
    r.ev   = ev;
    r.idx  = IDX_W'(idx);
    r.pos  = pos;
    r.last = lst;
    reports_due.push_back(r);
  endfunction

  function automatic void close_frame();
    frame_open   = 1'b0;
    frame_bytes  = 0;
    engine_armed = 1'b0;
    pair_seen    = 1'b0;
  endfunction

  function automatic void clear_commands();
    for (int i = 0; i < SERVO_COUNT; i++) cmd_valid[i] = 1'b0;
  endfunction

  function automatic void decode_rx_byte(logic [7:0] b);
    int top;
    int eidx;
    logic [7:0] p;
    top = -1;
    if (b == code_reg[CFG_FRAME_START]) begin
      clear_commands();
      close_frame();
      frame_open = 1'b1;
      add_report(EV_NONE, 0, 8'd0, 1'b1);
    end else if (b == code_reg[CFG_FRAME_END]) begin
      if (frame_open && pair_seen) begin
        for (int i = 0; i < SERVO_COUNT; i++) if (cmd_valid[i]) top = i;
        if (top < 0) add_report(EV_NONE, 0, 8'd0, 1'b1);
        for (int i = 0; i <= top; i++) begin
          if (cmd_valid[i]) begin
            p = cmd_code[i] - code_reg[CFG_DEGREE_LOW];
            add_report(EV_ENTRY, i, p, i == top);
          end
        end
        frames_accepted++;
      end else begin
        add_report(EV_REJECT, 0, 8'd0, 1'b1);
      end
      close_frame();
    end else if (b == code_reg[CFG_STOP]) begin
      clear_commands();
      pair_seen = 1'b0;
      add_report(EV_STOP, 0, 8'd0, 1'b1);
    end else if (!frame_open) begin
      add_report(EV_REJECT, 0, 8'd0, 1'b1);
    end else if (b == 8'd0) begin
      add_report(EV_NONE, 0, 8'd0, 1'b1);
    end else begin
      frame_bytes++;
      if (frame_bytes >= MAX_BYTES) begin
        close_frame();
        add_report(EV_REJECT, 0, 8'd0, 1'b1);
      end else begin
        if (b >= code_reg[CFG_ENGINE_FIRST] && b <= code_reg[CFG_ENGINE_LAST]) begin
          eidx = int'(b) - int'(code_reg[CFG_ENGINE_FIRST]);
          if (eidx < SERVO_COUNT) begin
            engine_armed = 1'b1;
            engine_sel   = 5'(eidx);
          end
        end else if (engine_armed && b >= code_reg[CFG_DEGREE_LOW] &&
                     b <= code_reg[CFG_DEGREE_HIGH]) begin
          engine_armed = 1'b0;
          cmd_code[engine_sel]  = b;
          cmd_valid[engine_sel] = 1'b1;
          pair_seen = 1'b1;
        end
        add_report(EV_NONE, 0, 8'd0, 1'b1);
      end
    end
  endfunction

  function automatic logic [7:0] pick_in_range(logic [7:0] lo, logic [7:0] hi);
    if (lo <= hi) return 8'($urandom_range(int'(hi), int'(lo)));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_byte(logic [7:0] b);
    int gap;
    if (send_idle_en && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_rx_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    code_reg[idx] = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(logic [7:0] start_c, logic [7:0] end_c, logic [7:0] stop_c,
                                logic [7:0] eng_lo, logic [7:0] eng_hi,
                                logic [7:0] deg_lo, logic [7:0] deg_hi);
    wait_drained();
    write_reg(CFG_FRAME_START, start_c);
    write_reg(CFG_FRAME_END, end_c);
    write_reg(CFG_STOP, stop_c);
    write_reg(CFG_ENGINE_FIRST, eng_lo);
    write_reg(CFG_ENGINE_LAST, eng_hi);
    write_reg(CFG_DEGREE_LOW, deg_lo);
    write_reg(CFG_DEGREE_HIGH, deg_hi);
    @(negedge clk);
  endtask

  task automatic test_basic_codes();
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(RST_FRAME_END);
    send_byte(RST_STOP);
    send_byte(RST_FRAME_START);
    send_byte(8'h00);
    send_byte(8'd200);
    send_byte(RST_ENGINE_FIRST);
    send_byte(RST_DEGREE_LOW);
    send_byte(RST_ENGINE_LAST);
    send_byte(RST_DEGREE_HIGH);
    send_byte(RST_FRAME_START);
    send_byte(RST_FRAME_END);
    send_byte(RST_FRAME_START);
    send_byte(8'd70);
    send_byte(8'd150);
    send_byte(RST_STOP);
    send_byte(8'd66);
    send_byte(8'd130);
    send_byte(RST_FRAME_END);
  endtask

  task automatic test_frame_limit();
    send_byte(RST_FRAME_START);
    repeat (7) send_byte(8'd1);
    send_byte(8'h00);
    repeat (7) send_byte(8'd1);
    send_byte(8'd1);
  endtask

  task automatic test_overlap_and_wrap();
    apply_settings(RST_FRAME_START, RST_FRAME_END, RST_STOP, RST_ENGINE_FIRST,
                   RST_ENGINE_LAST, 8'd200, RST_DEGREE_HIGH);
    send_byte(RST_FRAME_START);
    send_byte(RST_ENGINE_FIRST);
    send_byte(8'd250);
    wait_drained();
    write_reg(CFG_DEGREE_LOW, 8'd255);
    send_byte(RST_FRAME_END);
    apply_settings(RST_FRAME_START, RST_FRAME_END, RST_STOP, 8'd100, 8'd200, 8'd150, 8'd255);
    send_byte(RST_FRAME_START);
    send_byte(8'd160);
    send_byte(8'd117);
    send_byte(8'd160);
    send_byte(8'd210);
    send_byte(8'd100);
    send_byte(8'd255);
    send_byte(RST_FRAME_END);
    wait_drained();
    write_reg(CFG_STOP, RST_FRAME_END);
    send_byte(RST_FRAME_END);
    wait_drained();
    write_reg(CFG_FRAME_START, RST_FRAME_END);
    send_byte(RST_FRAME_END);
    send_byte(8'd101);
    send_byte(8'd180);
    send_byte(RST_FRAME_END);
  endtask

  task automatic send_random_frame();
    int pairs;
    pairs = $urandom_range(1, 6);
    send_byte(code_reg[CFG_FRAME_START]);
    repeat (pairs) begin
      case ($urandom_range(19))
        0: send_byte(8'($urandom_range(255)));
        1: send_byte(code_reg[CFG_STOP]);
        2: send_byte(8'h00);
        default: ;
      endcase
      send_byte(pick_in_range(code_reg[CFG_ENGINE_FIRST], code_reg[CFG_ENGINE_LAST]));
      send_byte(pick_in_range(code_reg[CFG_DEGREE_LOW], code_reg[CFG_DEGREE_HIGH]));
    end
    if ($urandom_range(9) != 0) send_byte(code_reg[CFG_FRAME_END]);
  endtask

  task automatic test_random_traffic(int n_items);
    int first;
    first = bytes_sent;
    while (bytes_sent - first < n_items) begin
      if ($urandom_range(99) < 80) send_random_frame();
      else send_byte(8'($urandom_range(255)));
      if ($urandom_range(99) < 4) wait_drained();
    end
  endtask

  always @(negedge clk) begin
    out_stall <= recv_idle_en && ($urandom_range(99) < 25);
  end

  always @(posedge clk) begin : check_results
    servo_report_t want;
    if (rst_n && out_xfer) begin
      if (reports_due.size() == 0) begin
        $error("result transfer with nothing expected: event_res %0d", out_event_res);
        fault_count++;
      end else begin
        want = reports_due.pop_front();
        results_checked++;
        if (out_event_res !== want.ev) begin
          $error("event_res expected %0d got %0d", want.ev, out_event_res);
          fault_count++;
        end
        if (out_servo_index !== want.idx) begin
          $error("servo_index expected %0d got %0d", want.idx, out_servo_index);
          fault_count++;
        end
        if (out_servo_position !== want.pos) begin
          $error("servo_position expected %0d got %0d", want.pos, out_servo_position);
          fault_count++;
        end
        if (out_last !== want.last) begin
          $error("last expected %0d got %0d", want.last, out_last);
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || in_xfer || out_xfer) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_FRAME_START;
    cfg_wdata    = 8'd0;
    in_valid     = 1'b0;
    in_rx_byte   = 8'd0;
    out_stall    = 1'b0;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    code_reg[CFG_FRAME_START]  = RST_FRAME_START;
    code_reg[CFG_FRAME_END]    = RST_FRAME_END;
    code_reg[CFG_STOP]         = RST_STOP;
    code_reg[CFG_ENGINE_FIRST] = RST_ENGINE_FIRST;
    code_reg[CFG_ENGINE_LAST]  = RST_ENGINE_LAST;
    code_reg[CFG_DEGREE_LOW]   = RST_DEGREE_LOW;
    code_reg[CFG_DEGREE_HIGH]  = RST_DEGREE_HIGH;
    close_frame();
    engine_sel = 5'd0;
    clear_commands();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_codes();
    test_frame_limit();
    test_overlap_and_wrap();

    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    apply_settings(RST_FRAME_START, RST_FRAME_END, RST_STOP, RST_ENGINE_FIRST,
                   RST_ENGINE_LAST, RST_DEGREE_LOW, RST_DEGREE_HIGH);
    test_random_traffic(55);
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    apply_settings(8'd0, 8'd255, 8'd1, 8'd2, 8'd19, 8'd20, 8'd254);
    test_random_traffic(55);
    apply_settings(8'd255, 8'd0, 8'd128, 8'd200, 8'd255, 8'd0, 8'd199);
    test_random_traffic(55);
    apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(200)), 8'($urandom_range(255, 200)),
                   8'($urandom_range(127)), 8'($urandom_range(255, 128)));
    test_random_traffic(55);

    wait_drained();
    repeat (40) @(negedge clk);
    if (reports_due.size() != 0) begin
      $error("%0d expected results never arrived", reports_due.size());
      fault_count++;
    end
    $display("Sent %0d bytes and checked %0d results, with %0d frames accepted.",
             bytes_sent, results_checked, frames_accepted);
    $display("Covered reset, extreme and random code settings with stalls on both sides.");
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
